[design/qpr_pkg.sv]
// ----------------------------------------------------------------------------
// qpr_pkg
// Shared types, constants and the arctangent table of the quadratic phase
// rotator.
// ----------------------------------------------------------------------------
package qpr_pkg;

    localparam int SAMPLE_WIDTH_DEF        = 16;
    localparam int INDEX_WIDTH_DEF         = 16;
    localparam int PHASE_FRACTION_BITS_DEF = 24;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOPE_Q         = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOG2_SLICE_SIZE = 1'b1;

    localparam int SLOPE_W    = 32;
    localparam int SLOPE_FRAC = 16;
    localparam int LOG2_W     = 5;
    localparam logic [LOG2_W-1:0] LOG2_RESET = 5'd12;

    // gain compensation, Q31
    localparam logic [30:0] GAIN_Q31   = 31'h4DBA76D4;
    localparam int          GUARD_BITS = 16;
    localparam int          GAIN_SHIFT = 31 - GUARD_BITS;

    // angles in units of 2^-32 turn
    localparam int ANG_W = 32;
    localparam int R_W   = 32;
    localparam logic [ANG_W-1:0] EIGHTH_TURN = 32'h2000_0000;

    localparam int CORDIC_STEPS    = 24;
    localparam int STEPS_PER_STAGE = 2;
    localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;

    localparam logic signed [R_W-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85032916,
        32'sd42667331,  32'sd21354465,  32'sd10680862,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41721,     32'sd20860,
        32'sd10430,     32'sd5215,      32'sd2607,      32'sd1303,
        32'sd651,       32'sd325,       32'sd162,       32'sd81
    };

    typedef struct packed {
        logic valid;
        logic last;
    } ctrl_t;

endpackage

[design/qpr_front.sv]
// ----------------------------------------------------------------------------
// qpr_front
// Phase generation and gain scaling: bin offset, square, slope multiply,
// rounding to a fraction of a turn, then coarse quadrant rotation.
// ----------------------------------------------------------------------------
module qpr_front #(
    parameter int SAMPLE_WIDTH        = qpr_pkg::SAMPLE_WIDTH_DEF,
    parameter int INDEX_WIDTH         = qpr_pkg::INDEX_WIDTH_DEF,
    parameter int PHASE_FRACTION_BITS = qpr_pkg::PHASE_FRACTION_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  qpr_pkg::ctrl_t                     in_ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0]     sample_real,
    input  logic signed [SAMPLE_WIDTH-1:0]     sample_imag,
    input  logic        [INDEX_WIDTH-1:0]      bin_index,
    input  logic signed [qpr_pkg::SLOPE_W-1:0] slope_q,
    input  logic        [qpr_pkg::LOG2_W-1:0]  log2_slice_size,
    output qpr_pkg::ctrl_t                     out_ctrl,
    output logic signed [SAMPLE_WIDTH+qpr_pkg::GUARD_BITS+1:0] x_out,
    output logic signed [SAMPLE_WIDTH+qpr_pkg::GUARD_BITS+1:0] y_out,
    output logic signed [qpr_pkg::R_W-1:0]     r_out
);
    import qpr_pkg::*;

    localparam int SW     = SAMPLE_WIDTH;
    localparam int IW     = INDEX_WIDTH;
    localparam int PF     = PHASE_FRACTION_BITS;
    localparam int D_W    = IW + 2;
    localparam int DSQ_W  = 2 * IW;
    localparam int PQ_W   = SLOPE_W + DSQ_W + 1;
    localparam int PROD_W = SLOPE_FRAC + 1 + IW;
    localparam int WIDE_W = PROD_W + PF;
    localparam int GX_W   = SW + 32;
    localparam int SCL_W  = SW + GUARD_BITS;
    localparam int CW     = SW + GUARD_BITS + 2;

    localparam logic signed [GX_W-1:0] GX_RND = GX_W'(1) << (GAIN_SHIFT - 1);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // stage 1: bin offset
    ctrl_t                    ctrl1_reg;
    logic signed [D_W-1:0]    d1_reg;
    logic [LOG2_W-1:0]        k1_reg;
    logic signed [SW-1:0]     xr1_reg;
    logic signed [SW-1:0]     yi1_reg;
    logic [LOG2_W-1:0]        k_next;
    logic [D_W-1:0]           half;
    logic signed [D_W-1:0]    d_next;

    // stage 2: square and gain
    ctrl_t                    ctrl2_reg;
    logic [DSQ_W-1:0]         dsq2_reg;
    logic [LOG2_W-1:0]        k2_reg;
    logic signed [SCL_W-1:0]  xs2_reg;
    logic signed [SCL_W-1:0]  ys2_reg;
    logic signed [2*D_W-1:0]  dd;
    logic signed [GX_W-1:0]   gx;
    logic signed [GX_W-1:0]   gy;
    logic signed [GX_W-1:0]   gx_sh;
    logic signed [GX_W-1:0]   gy_sh;

    // stage 3: slope product
    ctrl_t                    ctrl3_reg;
    logic [PROD_W-1:0]        prod3_reg;
    logic [LOG2_W-1:0]        k3_reg;
    logic signed [SCL_W-1:0]  xs3_reg;
    logic signed [SCL_W-1:0]  ys3_reg;
    logic signed [PQ_W-1:0]   pq;

    // stage 4: phase and angle split
    ctrl_t                    ctrl4_reg;
    logic [1:0]               quad4_reg;
    logic signed [R_W-1:0]    r4_reg;
    logic signed [SCL_W-1:0]  xs4_reg;
    logic signed [SCL_W-1:0]  ys4_reg;
    logic [WIDE_W-1:0]        wide;
    logic [WIDE_W-1:0]        rnd;
    logic [WIDE_W-1:0]        sh;
    logic [PF-1:0]            phi;
    logic [ANG_W-1:0]         ang;
    logic signed [29:0]       r30;

    // stage 5: quadrant
    ctrl_t                    ctrl5_reg;
    logic signed [CW-1:0]     x5_reg;
    logic signed [CW-1:0]     y5_reg;
    logic signed [R_W-1:0]    r5_reg;
    logic signed [CW-1:0]     xe;
    logic signed [CW-1:0]     ye;
    logic signed [CW-1:0]     x5_next;
    logic signed [CW-1:0]     y5_next;

    always_comb
    begin
        if (log2_slice_size < LOG2_W'(1))
        begin
            k_next = LOG2_W'(1);
        end
        else if (log2_slice_size > LOG2_W'(IW))
        begin
            k_next = LOG2_W'(IW);
        end
        else
        begin
            k_next = log2_slice_size;
        end
        half   = D_W'(1) << (k_next - LOG2_W'(1));
        d_next = $signed({2'b00, bin_index}) - $signed(half);
    end

    always_comb
    begin
        dd    = d1_reg * d1_reg;
        gx    = ($signed(xr1_reg) * $signed({1'b0, GAIN_Q31})) + GX_RND;
        gy    = ($signed(yi1_reg) * $signed({1'b0, GAIN_Q31})) + GX_RND;
        gx_sh = gx >>> GAIN_SHIFT;
        gy_sh = gy >>> GAIN_SHIFT;
    end

    always_comb
    begin
        pq = slope_q * $signed({1'b0, dsq2_reg});
    end

    // phi = round(prod * 2^PF / 2^(17+k)) mod 1 turn
    always_comb
    begin
        wide = WIDE_W'(prod3_reg) << PF;
        rnd  = wide + (WIDE_W'(1) << (SLOPE_FRAC + int'(k3_reg)));
        sh   = rnd >> (SLOPE_FRAC + 1 + int'(k3_reg));
        phi  = sh[PF-1:0];
        ang  = ANG_W'(0) - (ANG_W'(phi) << (ANG_W - PF)) + EIGHTH_TURN;
        r30  = {~ang[29], ang[28:0]};
    end

    always_comb
    begin
        xe = CW'(xs4_reg);
        ye = CW'(ys4_reg);
        unique case (quad4_reg)
            QUAD_0:
            begin
                x5_next = xe;
                y5_next = ye;
            end
            QUAD_1:
            begin
                x5_next = -ye;
                y5_next = xe;
            end
            QUAD_2:
            begin
                x5_next = -xe;
                y5_next = -ye;
            end
            QUAD_3:
            begin
                x5_next = ye;
                y5_next = -xe;
            end
            default:
            begin
                x5_next = xe;
                y5_next = ye;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl1_reg <= '0;
            ctrl2_reg <= '0;
            ctrl3_reg <= '0;
            ctrl4_reg <= '0;
            ctrl5_reg <= '0;
        end
        else if (en)
        begin
            ctrl1_reg <= in_ctrl;
            ctrl2_reg <= ctrl1_reg;
            ctrl3_reg <= ctrl2_reg;
            ctrl4_reg <= ctrl3_reg;
            ctrl5_reg <= ctrl4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg    <= d_next;
            k1_reg    <= k_next;
            xr1_reg   <= sample_real;
            yi1_reg   <= sample_imag;

            dsq2_reg  <= dd[DSQ_W-1:0];
            k2_reg    <= k1_reg;
            xs2_reg   <= gx_sh[SCL_W-1:0];
            ys2_reg   <= gy_sh[SCL_W-1:0];

            prod3_reg <= pq[PROD_W-1:0];
            k3_reg    <= k2_reg;
            xs3_reg   <= xs2_reg;
            ys3_reg   <= ys2_reg;

            quad4_reg <= ang[31:30];
            r4_reg    <= R_W'(r30);
            xs4_reg   <= xs3_reg;
            ys4_reg   <= ys3_reg;

            x5_reg    <= x5_next;
            y5_reg    <= y5_next;
            r5_reg    <= r4_reg;
        end
    end

    assign out_ctrl = ctrl5_reg;
    assign x_out    = x5_reg;
    assign y_out    = y5_reg;
    assign r_out    = r5_reg;

endmodule

[design/qpr_cordic_stage.sv]
// ----------------------------------------------------------------------------
// qpr_cordic_stage
// One register stage of the fine rotation: a fixed number of CORDIC
// micro-rotations starting at step FIRST_STEP.
// ----------------------------------------------------------------------------
module qpr_cordic_stage #(
    parameter int CW         = qpr_pkg::SAMPLE_WIDTH_DEF + qpr_pkg::GUARD_BITS + 2,
    parameter int FIRST_STEP = 0
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  qpr_pkg::ctrl_t                 in_ctrl,
    input  logic signed [CW-1:0]           x_in,
    input  logic signed [CW-1:0]           y_in,
    input  logic signed [qpr_pkg::R_W-1:0] r_in,
    output qpr_pkg::ctrl_t                 out_ctrl,
    output logic signed [CW-1:0]           x_out,
    output logic signed [CW-1:0]           y_out,
    output logic signed [qpr_pkg::R_W-1:0] r_out
);
    import qpr_pkg::*;

    ctrl_t                 ctrl_reg;
    logic signed [CW-1:0]  x_reg;
    logic signed [CW-1:0]  y_reg;
    logic signed [R_W-1:0] r_reg;
    logic signed [CW-1:0]  x_next;
    logic signed [CW-1:0]  y_next;
    logic signed [R_W-1:0] r_next;

    always_comb
    begin
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        x_next = x_in;
        y_next = y_in;
        r_next = r_in;
        for (int j = 0; j < STEPS_PER_STAGE; j++)
        begin
            xs = x_next >>> (FIRST_STEP + j);
            ys = y_next >>> (FIRST_STEP + j);
            if (r_next >= 0)
            begin
                x_next = x_next - ys;
                y_next = y_next + xs;
                r_next = r_next - ATAN_TABLE[FIRST_STEP + j];
            end
            else
            begin
                x_next = x_next + ys;
                y_next = y_next - xs;
                r_next = r_next + ATAN_TABLE[FIRST_STEP + j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (en)
        begin
            ctrl_reg <= in_ctrl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            r_reg <= r_next;
        end
    end

    assign out_ctrl = ctrl_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign r_out    = r_reg;

endmodule

[design/quadratic_phase_rotator_core.sv]
// ----------------------------------------------------------------------------
// quadratic_phase_rotator_core
// Chirp multiply: rotates each complex sample by -q*pi/N*(i-N/2)^2.
// ----------------------------------------------------------------------------
// One sample is taken per clock while the pipeline does not stall: five
// stages form the phase and scale the sample, twelve stages of two CORDIC
// steps each do the fine rotation, and the output register rounds and
// saturates. When the output request is not taken, the front and CORDIC
// stages still advance while the last CORDIC stage is empty, and they stall
// together once that stage holds a request; a stall loses or repeats nothing.
// slope_q and log2_slice_size are to be written only while the pipeline is empty.
module quadratic_phase_rotator_core #(
    parameter int SAMPLE_WIDTH        = qpr_pkg::SAMPLE_WIDTH_DEF,
    parameter int INDEX_WIDTH         = qpr_pkg::INDEX_WIDTH_DEF,
    parameter int PHASE_FRACTION_BITS = qpr_pkg::PHASE_FRACTION_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // sample_real, sample_imag, bin_index
    input  logic [((2*SAMPLE_WIDTH+INDEX_WIDTH+7)/8)*8-1:0] s_tdata,
    // last_in_slice
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // rotated_real, rotated_imag
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]   m_tdata,
    // last_out
    output logic                                  m_tlast,
    input  logic                                  cfg_we,
    input  logic [qpr_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [qpr_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import qpr_pkg::*;

    localparam int SW       = SAMPLE_WIDTH;
    localparam int IW       = INDEX_WIDTH;
    localparam int CW       = SW + GUARD_BITS + 2;
    localparam int M_DATA_W = ((2*SW+7)/8)*8;

    localparam logic signed [CW-1:0] OUT_RND = CW'(1) << (GUARD_BITS - 1);
    localparam logic signed [CW-1:0] SAT_MAX = (CW'(1) << (SW - 1)) - CW'(1);
    localparam logic signed [CW-1:0] SAT_MIN = -(CW'(1) << (SW - 1));

    logic signed [SLOPE_W-1:0] slope_q_reg;
    logic [LOG2_W-1:0]         log2_slice_reg;

    ctrl_t                     front_in_ctrl;
    logic                      en;

    ctrl_t                     chain_ctrl [CORDIC_STAGES+1];
    logic signed [CW-1:0]      chain_x    [CORDIC_STAGES+1];
    logic signed [CW-1:0]      chain_y    [CORDIC_STAGES+1];
    logic signed [R_W-1:0]     chain_r    [CORDIC_STAGES+1];

    logic signed [CW-1:0]      xr_full;
    logic signed [CW-1:0]      yr_full;
    logic signed [SW-1:0]      rot_real_next;
    logic signed [SW-1:0]      rot_imag_next;

    logic                      out_valid_reg;
    logic                      out_last_reg;
    logic signed [SW-1:0]      rot_real_reg;
    logic signed [SW-1:0]      rot_imag_reg;
    logic                      out_hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slope_q_reg    <= '0;
            log2_slice_reg <= LOG2_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SLOPE_Q:         slope_q_reg    <= cfg_data[SLOPE_W-1:0];
                REG_LOG2_SLICE_SIZE: log2_slice_reg <= cfg_data[LOG2_W-1:0];
                default:             ;
            endcase
        end
    end

    assign out_hold      = out_valid_reg && !m_tready;
    assign en            = !(chain_ctrl[CORDIC_STAGES].valid && out_hold);
    assign s_tready      = en;
    assign front_in_ctrl = '{valid: s_tvalid, last: s_tlast};

    qpr_front #(
        .SAMPLE_WIDTH        (SAMPLE_WIDTH),
        .INDEX_WIDTH         (INDEX_WIDTH),
        .PHASE_FRACTION_BITS (PHASE_FRACTION_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .in_ctrl         (front_in_ctrl),
        .sample_real     (s_tdata[SW-1:0]),
        .sample_imag     (s_tdata[2*SW-1:SW]),
        .bin_index       (s_tdata[2*SW+IW-1:2*SW]),
        .slope_q         (slope_q_reg),
        .log2_slice_size (log2_slice_reg),
        .out_ctrl        (chain_ctrl[0]),
        .x_out           (chain_x[0]),
        .y_out           (chain_y[0]),
        .r_out           (chain_r[0])
    );

    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cordic
        qpr_cordic_stage #(
            .CW         (CW),
            .FIRST_STEP (g * STEPS_PER_STAGE)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_ctrl  (chain_ctrl[g]),
            .x_in     (chain_x[g]),
            .y_in     (chain_y[g]),
            .r_in     (chain_r[g]),
            .out_ctrl (chain_ctrl[g+1]),
            .x_out    (chain_x[g+1]),
            .y_out    (chain_y[g+1]),
            .r_out    (chain_r[g+1])
        );
    end

    // drop guard bits, round half up, saturate
    always_comb
    begin
        xr_full = (chain_x[CORDIC_STAGES] + OUT_RND) >>> GUARD_BITS;
        yr_full = (chain_y[CORDIC_STAGES] + OUT_RND) >>> GUARD_BITS;
        priority if (xr_full > SAT_MAX)
            rot_real_next = SAT_MAX[SW-1:0];
        else if (xr_full < SAT_MIN)
            rot_real_next = SAT_MIN[SW-1:0];
        else
            rot_real_next = xr_full[SW-1:0];
        priority if (yr_full > SAT_MAX)
            rot_imag_next = SAT_MAX[SW-1:0];
        else if (yr_full < SAT_MIN)
            rot_imag_next = SAT_MIN[SW-1:0];
        else
            rot_imag_next = yr_full[SW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_hold)
        begin
            out_valid_reg <= chain_ctrl[CORDIC_STAGES].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_hold && chain_ctrl[CORDIC_STAGES].valid)
        begin
            rot_real_reg <= rot_real_next;
            rot_imag_reg <= rot_imag_next;
            out_last_reg <= chain_ctrl[CORDIC_STAGES].last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'({rot_imag_reg, rot_real_reg});
    assign m_tlast  = out_last_reg;

endmodule

[test/quadratic_phase_rotator_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_phase_rotator_core_test
// Self-checking bench for the chirp multiply core. Sample requests go in on
// the slave stream and each one is predicted in a scoreboard class. The
// scoreboard forms the quadratic phase and runs the CORDIC rotation in
// 64-bit integers. Every rotated request that leaves the master stream is
// compared in order with the oldest prediction. The run walks through several
// slope and slice-size settings, with random gaps on the input side and
// random back-pressure on the output side.
// ----------------------------------------------------------------------------
module quadratic_phase_rotator_core_test;

    localparam int SW   = 16;
    localparam int IW   = 16;
    localparam int PFB  = 24;
    localparam int STEPS = 24;

    typedef struct packed {
        logic              last;
        logic [IW-1:0]     bin;
        logic signed [SW-1:0] im;
        logic signed [SW-1:0] re;
    } sample_t;

    typedef struct packed {
        logic              last;
        logic signed [SW-1:0] im;
        logic signed [SW-1:0] re;
    } rotation_t;

    class rotation_scoreboard;
        logic signed [31:0] slope;
        logic [4:0]         log2_size;
        rotation_t          expected_q[$];
        int                 failures;

        function new();
            slope     = '0;
            log2_size = qpr_pkg::LOG2_RESET;
            failures  = 0;
        endfunction

        function automatic longint round_saturate(longint v);
            longint r;
            r = (v + (longint'(1) <<< (qpr_pkg::GUARD_BITS - 1))) >>> qpr_pkg::GUARD_BITS;
            if (r > 32767)
                r = 32767;
            if (r < -32768)
                r = -32768;
            return r;
        endfunction

        function automatic rotation_t rotate(sample_t smp);
            rotation_t  res;
            longint     k, d, x, y, t, r, xs, ys, gain;
            logic [63:0] q64, dd, prod, phi;
            logic [31:0] ang;
            logic [1:0]  quad;
            int          s;
            k = log2_size;
            if (k < 1)
                k = 1;
            if (k > IW)
                k = IW;
            d    = longint'(smp.bin) - (longint'(1) <<< (k - 1));
            q64  = longint'(slope);
            dd   = d * d;
            prod = q64 * dd;
            s    = 17 + int'(k) - PFB;
            if (s > 0)
                phi = (prod + (64'd1 << (s - 1))) >> s;
            else
                phi = prod << (-s);
            ang  = 32'd0 - {phi[PFB-1:0], {(32-PFB){1'b0}}};
            ang  = ang + qpr_pkg::EIGHTH_TURN;
            quad = ang[31:30];
            r    = longint'({2'b00, ang[29:0]}) - longint'(qpr_pkg::EIGHTH_TURN);

            gain = longint'(qpr_pkg::GAIN_Q31);
            x = (longint'(smp.re) * gain + (longint'(1) <<< (qpr_pkg::GAIN_SHIFT - 1)))
                >>> qpr_pkg::GAIN_SHIFT;
            y = (longint'(smp.im) * gain + (longint'(1) <<< (qpr_pkg::GAIN_SHIFT - 1)))
                >>> qpr_pkg::GAIN_SHIFT;

            case (quad)
                2'd1:
                begin
                    t = x; x = -y; y = t;
                end
                2'd2:
                begin
                    x = -x; y = -y;
                end
                2'd3:
                begin
                    t = x; x = y; y = -t;
                end
                default: ;
            endcase

            for (int i = 0; i < STEPS; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (r >= 0)
                begin
                    x = x - ys; y = y + xs; r = r - longint'(qpr_pkg::ATAN_TABLE[i]);
                end
                else
                begin
                    x = x + ys; y = y - xs; r = r + longint'(qpr_pkg::ATAN_TABLE[i]);
                end
            end

            res.re   = SW'(round_saturate(x));
            res.im   = SW'(round_saturate(y));
            res.last = smp.last;
            return res;
        endfunction

        function void note_sample(sample_t smp);
            expected_q.push_back(rotate(smp));
        endfunction

        function void check_rotation(rotation_t got);
            rotation_t want;
            if (expected_q.size() == 0)
            begin
                $error("unexpected request: rotated_real %0d rotated_imag %0d last_out %0d",
                       got.re, got.im, got.last);
                failures++;
                return;
            end
            want = expected_q.pop_front();
            if (got.re !== want.re)
            begin
                $error("rotated_real: expected %0d, actual %0d", want.re, got.re);
                failures++;
            end
            if (got.im !== want.im)
            begin
                $error("rotated_imag: expected %0d, actual %0d", want.im, got.im);
                failures++;
            end
            if (got.last !== want.last)
            begin
                $error("last_out: expected %0d, actual %0d", want.last, got.last);
                failures++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we;
    logic [qpr_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [qpr_pkg::CFG_DATA_W-1:0]  cfg_data;

    int send_idle_pct;
    int recv_stall_pct;

    rotation_scoreboard rotations = new();

    quadratic_phase_rotator_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("[quadratic_phase_rotator_core] ERROR");
        $finish;
    end

    // output side back-pressure
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        rotation_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.re   = m_tdata[15:0];
            got.im   = m_tdata[31:16];
            got.last = m_tlast;
            rotations.check_rotation(got);
        end
    end

    task automatic send_sample(sample_t smp);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {smp.bin, smp.im, smp.re};
        s_tlast  = smp.last;
        do
            @(posedge clk);
        while (!s_tready);
        rotations.note_sample(smp);
    endtask

    task automatic wait_drain();
        int n;
        n = 0;
        while (rotations.expected_q.size() != 0 && n < 20000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (24) @(posedge clk);
    endtask

    task automatic write_reg(logic [qpr_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] value);
        @(negedge clk);
        s_tvalid  = 1'b0;
        wait_drain();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        if (idx == qpr_pkg::REG_SLOPE_Q)
            rotations.slope = value;
        else
            rotations.log2_size = value[4:0];
    endtask

    function automatic logic signed [SW-1:0] pick_component();
        case ($urandom_range(5))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return SW'($urandom_range(15)) - 16'sd8;
            default: return SW'($urandom);
        endcase
    endfunction

    function automatic sample_t random_sample(int k);
        sample_t smp;
        int      n;
        if (k < 1)
            k = 1;
        if (k > IW)
            k = IW;
        n = 1 << k;
        smp.re = pick_component();
        smp.im = pick_component();
        if ($urandom_range(99) < 85)
            smp.bin = IW'($urandom_range(n - 1));
        else
            smp.bin = IW'($urandom);
        smp.last = (smp.bin == IW'(n - 1)) || ($urandom_range(7) == 0);
        return smp;
    endfunction

    function automatic sample_t make_sample(int re, int im, int bin, bit last);
        sample_t smp;
        smp.re   = SW'(re);
        smp.im   = SW'(im);
        smp.bin  = IW'(bin);
        smp.last = last;
        return smp;
    endfunction

    task automatic set_idle_mode(int mode);
        case (mode % 4)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 52; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 52; end
            default: begin send_idle_pct = 12; recv_stall_pct = 12; end
        endcase
    endtask

    logic [31:0] slope_set [8];
    logic [4:0]  log2_set  [8];

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: zero slope, phase stays at zero
        send_sample(make_sample(32767, -32768, 0, 1'b0));
        send_sample(make_sample(-32768, -32768, 2048, 1'b1));
        send_sample(make_sample(32767, 32767, 4095, 1'b0));

        // small slice, slope 1.5
        write_reg(qpr_pkg::REG_SLOPE_Q, 32'h0001_8000);
        write_reg(qpr_pkg::REG_LOG2_SLICE_SIZE, 32'd4);
        for (int b = 0; b < 16; b++)
        begin
            case (b % 4)
                0: send_sample(make_sample(32767, 32767, b, b == 15));
                1: send_sample(make_sample(-32768, 32767, b, b == 15));
                2: send_sample(make_sample(-32768, -32768, b, b == 15));
                default: send_sample(make_sample(1000 * b - 7000, 0, b, b == 15));
            endcase
        end
        // bin beyond the slice
        send_sample(make_sample(32767, -32768, 16, 1'b0));
        send_sample(make_sample(-32768, 32767, 65535, 1'b1));

        slope_set[0] = 32'h7FFF_FFFF; log2_set[0] = 5'd16;
        slope_set[1] = 32'h8000_0000; log2_set[1] = 5'd1;
        slope_set[2] = $urandom;      log2_set[2] = 5'd0;
        slope_set[3] = $urandom;      log2_set[3] = 5'd31;
        slope_set[4] = $urandom;      log2_set[4] = 5'd12;
        slope_set[5] = 32'h0001_0000; log2_set[5] = 5'd8;
        slope_set[6] = $urandom;      log2_set[6] = 5'($urandom_range(31));
        slope_set[7] = 32'hFFFF_0000; log2_set[7] = 5'd10;

        for (int p = 0; p < 8; p++)
        begin
            write_reg(qpr_pkg::REG_SLOPE_Q, slope_set[p]);
            write_reg(qpr_pkg::REG_LOG2_SLICE_SIZE, {27'd0, log2_set[p]});
            set_idle_mode(p);
            for (int n = 0; n < 94; n++)
                send_sample(random_sample(int'(log2_set[p])));
        end

        @(negedge clk);
        s_tvalid = 1'b0;
        wait_drain();
        if (rotations.expected_q.size() != 0)
        begin
            $error("%0d requests never left the core", rotations.expected_q.size());
            rotations.failures++;
        end
        if (rotations.failures == 0)
            $display("[quadratic_phase_rotator_core] OK");
        else
            $display("[quadratic_phase_rotator_core] ERROR");
        $finish;
    end

endmodule

[files.f]
design/qpr_pkg.sv
design/qpr_front.sv
design/qpr_cordic_stage.sv
design/quadratic_phase_rotator_core.sv
test/quadratic_phase_rotator_core_test.sv
